>>> rtl/bpa_pkg.sv
// Shared constants, codes and types of the bitmap page allocator.
// Used by the controller, the output register, the top level and the checker.
// No dependencies.
`timescale 1ns / 1ps

package bpa_pkg;

	// Sizing of the managed memory
	localparam int MAX_PAGES     = 262144;
	localparam int PAGE_BYTES    = 4096;
	localparam int RESERVED_BASE = 2097152;

	localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
	localparam int MAP_WORDS  = (MAX_PAGES + 31) / 32;
	localparam int MAP_AW     = $clog2(MAP_WORDS);
	localparam int WCNT_W     = $clog2(MAP_WORDS + 1);
	localparam int CNT_W      = $clog2(MAX_PAGES + 1);
	localparam int ADDR_W     = 32;
	localparam int PN_W       = ADDR_W - PAGE_SHIFT;
	localparam int PIDX_W     = MAP_AW + 5;
	localparam int KB_W       = 22;
	localparam int MB_W       = 11;
	localparam int MB_SHIFT   = 8;
	localparam int CMD_W      = 2;
	localparam int STAT_W     = 2;
	localparam int IN_W       = 40;
	localparam int OUT_W      = STAT_W + ADDR_W + CNT_W + MB_W;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;

	// Status codes
	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NO_FREE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_IGNORED = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_INIT,
		ST_SCAN,
		ST_FREE_RD,
		ST_FREE_CHK,
		ST_RESP
	} state_t;

	// Result beat, status in the lowest bits
	typedef struct packed {
		logic [MB_W-1:0]   free_megabytes;
		logic [CNT_W-1:0]  free_pages;
		logic [ADDR_W-1:0] alloc_address;
		logic [STAT_W-1:0] status;
	} res_t;

	// Bitmap memory request from the controller
	typedef struct packed {
		logic              we;
		logic [MAP_AW-1:0] waddr;
		logic [31:0]       wdata;
		logic              re;
		logic [MAP_AW-1:0] raddr;
	} map_req_t;

endpackage

>>> rtl/bpa_map_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Holds the page bitmap; no dependencies.
`timescale 1ns / 1ps

module bpa_map_ram #(
	parameter int AW = 13,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/bpa_ctrl.sv
// Command sequencer of the page allocator: init sweep, first-fit scan, free check.
// Depends on bpa_pkg; drives the bitmap RAM and the output register.
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bpa_pkg::KB_W-1:0]   cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [bpa_pkg::CMD_W-1:0]  in_cmd,
	input  logic [bpa_pkg::ADDR_W-1:0] in_addr,
	input  logic                       out_free,
	output logic                       res_load,
	output bpa_pkg::res_t              res,
	output bpa_pkg::map_req_t          map_req,
	input  logic [31:0]                map_rdata
);
	import bpa_pkg::*;

	// Isolate the lowest zero bit of a word as a one-hot mask
	function automatic logic [31:0] low_zero(input logic [31:0] v);
		logic [31:0] inv;
		inv = ~v;
		return inv & (~inv + 32'd1);
	endfunction

	// Encode a one-hot mask to its bit index
	function automatic logic [4:0] onehot_idx(input logic [31:0] oh);
		logic [4:0] idx;
		idx = '0;
		for (int j = 0; j < 32; j++) begin
			if (oh[j]) begin
				idx = idx | 5'(j);
			end
		end
		return idx;
	endfunction

	state_t state_q, state_d;

	logic [KB_W-1:0]   upper_kb_q;
	logic [CNT_W-1:0]  page_count_q;
	logic [CNT_W-1:0]  free_count_q;
	logic [WCNT_W-1:0] words_q;
	logic [PN_W-1:0]   res_end_q;
	logic [MAP_AW-1:0] idx_q;
	logic [WCNT_W-1:0] issue_q;
	logic              vld_s1;
	logic [MAP_AW-1:0] w_s1;
	logic [PN_W-1:0]   pn_q;
	logic [STAT_W-1:0] status_q;
	logic [ADDR_W-1:0] alloc_q;

	logic              accept;
	logic [KB_W:0]     total_kb;
	logic [KB_W+10:0]  total_bytes;
	logic [KB_W+10:0]  pages_raw;
	logic [CNT_W-1:0]  page_count_n;
	logic [WCNT_W-1:0] words_c;
	logic [31:0]       res_bytes;
	logic [PN_W-1:0]   res_end_c;
	logic [CNT_W-1:0]  free_init_c;
	logic [31:0]       sweep_word;
	logic              issue;
	logic              scan_hit;
	logic              scan_empty;
	logic [31:0]       hit_mask;
	logic [PIDX_W-1:0] hit_page;
	logic              hit_fits;
	logic              free_in_range;
	logic [31:0]       free_mask;
	logic              free_used;

	assign accept = in_valid && in_ready;

	// Size the map from the configured memory
	assign total_kb     = (KB_W+1)'(upper_kb_q) + (KB_W+1)'(1024);
	assign total_bytes  = {total_kb, 10'b0};
	assign pages_raw    = total_bytes >> PAGE_SHIFT;
	assign page_count_n = (pages_raw > (KB_W+11)'(MAX_PAGES)) ? CNT_W'(MAX_PAGES)
	                                                          : CNT_W'(pages_raw);

	// Reserved region end and initial free count
	assign words_c     = WCNT_W'(((CNT_W+1)'(page_count_q) + (CNT_W+1)'(31)) >> 5);
	assign res_bytes   = 32'(RESERVED_BASE) + (32'(words_c) << 2) + 32'(PAGE_BYTES - 1);
	assign res_end_c   = PN_W'(res_bytes >> PAGE_SHIFT);
	assign free_init_c = (res_end_c < PN_W'(page_count_q))
	                   ? CNT_W'(PN_W'(page_count_q) - res_end_c) : '0;

	// Build one bitmap word of the init sweep: free inside the window, else used
	always_comb begin
		logic [PIDX_W-1:0] p;
		sweep_word = '1;
		for (int b = 0; b < 32; b++) begin
			p = {idx_q, 5'(b)};
			if ((PN_W'(p) >= res_end_q) && (PN_W'(p) < PN_W'(page_count_q))) begin
				sweep_word[b] = 1'b0;
			end
		end
	end

	// First-fit scan over the words in use
	assign issue      = (issue_q < words_q);
	assign scan_hit   = vld_s1 && (map_rdata != '1);
	assign scan_empty = !vld_s1 && !issue;
	assign hit_mask   = low_zero(map_rdata);
	assign hit_page   = {w_s1, onehot_idx(hit_mask)};
	assign hit_fits   = (32'(hit_page) < 32'(page_count_q));

	// Free request check
	assign free_in_range = (32'(pn_q) < 32'(page_count_q));
	assign free_mask     = 32'd1 << pn_q[4:0];
	assign free_used     = map_rdata[pn_q[4:0]];

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_cmd)
						CMD_ALLOC: state_d = ST_SCAN;
						CMD_FREE:  state_d = ST_FREE_RD;
						CMD_INIT:  state_d = ST_PREP;
						default:   state_d = ST_RESP;
					endcase
				end
			end
			ST_PREP:     state_d = ST_INIT;
			ST_INIT:     if (idx_q == MAP_AW'(MAP_WORDS - 1)) state_d = ST_RESP;
			ST_SCAN:     if (scan_hit || scan_empty) state_d = ST_RESP;
			ST_FREE_RD:  state_d = free_in_range ? ST_FREE_CHK : ST_RESP;
			ST_FREE_CHK: state_d = ST_RESP;
			ST_RESP:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Handshake and memory controls
	always_comb begin
		in_ready = 1'b0;
		res_load = 1'b0;
		map_req  = '0;
		unique case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_INIT: begin
				map_req.we    = 1'b1;
				map_req.waddr = idx_q;
				map_req.wdata = sweep_word;
			end
			ST_SCAN: begin
				map_req.re    = issue;
				map_req.raddr = issue_q[MAP_AW-1:0];
				map_req.we    = scan_hit && hit_fits;
				map_req.waddr = w_s1;
				map_req.wdata = map_rdata | hit_mask;
			end
			ST_FREE_RD: begin
				map_req.re    = free_in_range;
				map_req.raddr = pn_q[PIDX_W-1:5];
			end
			ST_FREE_CHK: begin
				map_req.we    = free_used;
				map_req.waddr = pn_q[PIDX_W-1:5];
				map_req.wdata = map_rdata & ~free_mask;
			end
			ST_RESP: res_load = out_free;
			default: ;
		endcase
	end

	// Control state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			upper_kb_q   <= '0;
			page_count_q <= '0;
			free_count_q <= '0;
			words_q      <= '0;
			idx_q        <= '0;
			issue_q      <= '0;
			vld_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				upper_kb_q <= cfg_wdata;
			end
			unique case (state_q)
				ST_IDLE: begin
					issue_q <= '0;
					vld_s1  <= 1'b0;
					if (accept && (in_cmd == CMD_INIT)) begin
						page_count_q <= page_count_n;
					end
				end
				ST_PREP: begin
					words_q      <= words_c;
					free_count_q <= free_init_c;
					idx_q        <= '0;
				end
				ST_INIT: idx_q <= idx_q + MAP_AW'(1);
				ST_SCAN: begin
					vld_s1 <= issue;
					if (issue) begin
						issue_q <= issue_q + WCNT_W'(1);
					end
					if (scan_hit && hit_fits && (free_count_q != '0)) begin
						free_count_q <= free_count_q - CNT_W'(1);
					end
				end
				ST_FREE_CHK: begin
					if (free_used) begin
						free_count_q <= free_count_q + CNT_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// Command payload and result fields
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					status_q <= STAT_OK;
					alloc_q  <= '0;
					pn_q     <= PN_W'(in_addr >> PAGE_SHIFT);
				end
			end
			ST_PREP: res_end_q <= res_end_c;
			ST_SCAN: begin
				w_s1 <= issue_q[MAP_AW-1:0];
				if (scan_hit) begin
					if (hit_fits) begin
						alloc_q <= ADDR_W'(hit_page) << PAGE_SHIFT;
					end else begin
						status_q <= STAT_NO_FREE;
					end
				end else if (scan_empty) begin
					status_q <= STAT_NO_FREE;
				end
			end
			ST_FREE_RD: if (!free_in_range) status_q <= STAT_IGNORED;
			ST_FREE_CHK: if (!free_used) status_q <= STAT_IGNORED;
			default: ;
		endcase
	end

	// Result beat
	assign res.status         = status_q;
	assign res.alloc_address  = alloc_q;
	assign res.free_pages     = free_count_q;
	assign res.free_megabytes = MB_W'(free_count_q >> MB_SHIFT);

endmodule

>>> rtl/bpa_out_reg.sv
// Output register of the result channel; frees the controller from the consumer.
// Depends on bpa_pkg.
`timescale 1ns / 1ps

module bpa_out_reg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  bpa_pkg::res_t             res,
	output logic                      slot_free,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bpa_pkg::OUT_W-1:0] m_tdata
);
	import bpa_pkg::*;

	logic valid_q;
	res_t data_q;

	assign slot_free = !valid_q || m_tready;

	// Hold valid until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Capture the result beat
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_W'(data_q);

endmodule

>>> rtl/bitmap_page_allocator_core.sv
// Top level of the bitmap first-fit page allocator.
// Depends on bpa_pkg, bpa_ctrl, bpa_map_ram and bpa_out_reg.
//
// channel   direction  handshake            payload
// cfg       in         cfg_we               cfg_wdata: upper memory size in KB
// s_*       in         s_tvalid / s_tready  s_tdata: cmd, page_address
// m_*       out        m_tvalid / m_tready  m_tdata: status, alloc_address,
//                                           free_pages, free_megabytes
//
// One command at a time; the next is accepted once the result is loaded into the output register.
// Alloc reads the bitmap words in turn through the word with the first free page;
// with no free page it reads every word in use, and none before any init.
// Free reads the page's word and clears the bit if set, reading nothing out of range;
// an unused code goes straight to the response; init makes one RAM write per map word.
// The map needs no clearing after reset: init rewrites every word before any page counts.
`timescale 1ns / 1ps

module bitmap_page_allocator_core (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [bpa_pkg::KB_W-1:0]  cfg_wdata,   // upper memory size in KB
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [bpa_pkg::IN_W-1:0]  s_tdata,     // cmd[1:0], page_address[33:2], zero pad
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bpa_pkg::OUT_W-1:0] m_tdata      // status[1:0], alloc_address[33:2],
	                                               // free_pages[52:34], free_megabytes[63:53]
);
	import bpa_pkg::*;

	map_req_t    map_req;
	logic [31:0] map_rdata;
	res_t        res;
	logic        res_load;
	logic        out_free;

	// Sequencer
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (s_tdata[CMD_W-1:0]),
		.in_addr   (s_tdata[CMD_W+ADDR_W-1:CMD_W]),
		.out_free  (out_free),
		.res_load  (res_load),
		.res       (res),
		.map_req   (map_req),
		.map_rdata (map_rdata)
	);

	// Page bitmap
	bpa_map_ram #(
		.AW (MAP_AW),
		.DW (32)
	) u_map (
		.clk   (clk),
		.we    (map_req.we),
		.waddr (map_req.waddr),
		.wdata (map_req.wdata),
		.re    (map_req.re),
		.raddr (map_req.raddr),
		.rdata (map_rdata)
	);

	// Result register
	bpa_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_load),
		.res       (res),
		.slot_free (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> rtl/bpa_checker.sv
// Port-level checks of the page allocator result channel, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_core.
`timescale 1ns / 1ps

module bpa_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [bpa_pkg::OUT_W-1:0] m_tdata
);
	import bpa_pkg::*;

	res_t beat;
	assign beat = res_t'(m_tdata);

	// Stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// Megabyte count follows the page count
	a_mb: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> beat.free_megabytes == MB_W'(beat.free_pages >> MB_SHIFT))
		else $error("free_megabytes does not match free_pages");

	// Only a successful alloc returns an address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (beat.status != STAT_OK) |-> beat.alloc_address == '0)
		else $error("address returned with a failing status");

	// Returned addresses are page aligned and counts stay in range
	a_align: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (beat.alloc_address[PAGE_SHIFT-1:0] == '0)
		          && (32'(beat.free_pages) <= 32'(MAX_PAGES)))
		else $error("misaligned address or free count out of range");

endmodule

bind bitmap_page_allocator_core bpa_checker u_bpa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.m_tdata   (m_tdata)
);
